// File: rtl/strided_dma_address_generator_core_assert.svh
// Assertion macros used by the strided DMA address generator core RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef STRIDED_DMA_ADDRESS_GENERATOR_CORE_ASSERT_SVH
`define STRIDED_DMA_ADDRESS_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sdag_pkg.sv
// Package for the strided DMA address generator: request and result types, constants.
// Used by sdag_beat_gen and strided_dma_address_generator_core; depends on nothing.
package sdag_pkg;

  localparam int LOCAL_W    = 12;
  localparam int MAIN_W     = 24;
  localparam int BEAT_BYTES = 8;
  localparam int BEAT_SHIFT = 3;
  localparam int ROW_W      = 9;
  localparam int CNT_W      = 8;
  localparam int SKIP_W     = 12;

  // Request function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] length_word;
    logic [12:0] local_address;
    logic [23:0] main_address;
    logic        to_main;
  } in_item_t;

  typedef struct packed {
    logic        beat_valid;
    logic [11:0] beat_local_address;
    logic [23:0] beat_main_address;
    logic        beat_use_imem;
    logic        beat_to_main;
    logic        last_beat;
    logic        busy_res;
  } out_item_t;

endpackage

// File: rtl/sdag_beat_gen.sv
// Transfer state and beat address generation for one request per enabled cycle.
// Depends on sdag_pkg for the request and result types and constants.
module sdag_beat_gen (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  sdag_pkg::in_item_t  item,
  output sdag_pkg::out_item_t result,
  output logic              active
);

  logic                         active_r, active_nxt;
  logic [sdag_pkg::LOCAL_W-1:0] cur_local_r, cur_local_nxt;
  logic [sdag_pkg::MAIN_W-1:0]  cur_main_r, cur_main_nxt;
  logic [sdag_pkg::ROW_W-1:0]   row_beats_r, row_beats_nxt;
  logic [sdag_pkg::ROW_W-1:0]   beats_left_r, beats_left_nxt;
  logic [sdag_pkg::CNT_W-1:0]   rows_left_r, rows_left_nxt;
  logic [sdag_pkg::SKIP_W-1:0]  skip_r, skip_nxt;
  logic                         bank_imem_r, bank_imem_nxt;
  logic                         dir_main_r, dir_main_nxt;

  logic                         row_end;
  logic                         last;
  logic [sdag_pkg::LOCAL_W-1:0] local_inc;
  logic [sdag_pkg::MAIN_W-1:0]  main_inc;

  assign row_end   = (beats_left_r == '0);
  assign last      = row_end && (rows_left_r == '0);
  assign local_inc = cur_local_r + sdag_pkg::LOCAL_W'(sdag_pkg::BEAT_BYTES);
  assign main_inc  = cur_main_r + sdag_pkg::MAIN_W'(sdag_pkg::BEAT_BYTES);
  assign active    = active_r;

  // Next state and the result of the current request.
  always_comb begin
    active_nxt     = active_r;
    cur_local_nxt  = cur_local_r;
    cur_main_nxt   = cur_main_r;
    row_beats_nxt  = row_beats_r;
    beats_left_nxt = beats_left_r;
    rows_left_nxt  = rows_left_r;
    skip_nxt       = skip_r;
    bank_imem_nxt  = bank_imem_r;
    dir_main_nxt   = dir_main_r;
    result         = '0;

    if (item.func == sdag_pkg::FUNC_START) begin
      // The row length rounds up to whole beats, so the beat count minus one
      // is simply the length field without its low beat-offset bits.
      row_beats_nxt  = item.length_word[11:sdag_pkg::BEAT_SHIFT];
      beats_left_nxt = item.length_word[11:sdag_pkg::BEAT_SHIFT];
      rows_left_nxt  = item.length_word[19:12];
      skip_nxt       = item.length_word[31:20];
      cur_local_nxt  = item.local_address[11:0];
      bank_imem_nxt  = item.local_address[12];
      cur_main_nxt   = item.main_address;
      dir_main_nxt   = item.to_main;
      active_nxt     = 1'b1;
      result.busy_res = 1'b1;
    end else if (active_r) begin
      cur_local_nxt = local_inc;
      cur_main_nxt  = main_inc;
      if (row_end) begin
        if (last) begin
          active_nxt = 1'b0;
        end else begin
          // Next row: reload the beat count and skip ahead in main memory only.
          rows_left_nxt  = rows_left_r - 1'b1;
          beats_left_nxt = row_beats_r;
          cur_main_nxt   = main_inc + sdag_pkg::MAIN_W'(skip_r);
        end
      end else begin
        beats_left_nxt = beats_left_r - 1'b1;
      end
      result.beat_valid         = 1'b1;
      result.beat_local_address = cur_local_r;
      result.beat_main_address  = cur_main_r;
      result.beat_use_imem      = bank_imem_r;
      result.beat_to_main       = dir_main_r;
      result.last_beat          = last;
      result.busy_res           = !last;
    end
  end

  // State registers, updated only when a request is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      cur_local_r  <= '0;
      cur_main_r   <= '0;
      row_beats_r  <= '0;
      beats_left_r <= '0;
      rows_left_r  <= '0;
      skip_r       <= '0;
      bank_imem_r  <= 1'b0;
      dir_main_r   <= 1'b0;
    end else if (step_en) begin
      active_r     <= active_nxt;
      cur_local_r  <= cur_local_nxt;
      cur_main_r   <= cur_main_nxt;
      row_beats_r  <= row_beats_nxt;
      beats_left_r <= beats_left_nxt;
      rows_left_r  <= rows_left_nxt;
      skip_r       <= skip_nxt;
      bank_imem_r  <= bank_imem_nxt;
      dir_main_r   <= dir_main_nxt;
    end
  end

endmodule

// File: rtl/strided_dma_address_generator_core.sv
// A request held in the input register passes through the beat generator into the result
// register whenever the result register is empty or being drained.
// Throughput: one request per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset (rst_n, synchronous, active low) empties both registers and clears the
// transfer state, so no transfer is active afterward.
`include "strided_dma_address_generator_core_assert.svh"

module strided_dma_address_generator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdag_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdag_pkg::out_item_t out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  sdag_pkg::in_item_t  s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  sdag_pkg::out_item_t out_data_r;
  sdag_pkg::out_item_t step_result;
  logic                advance;
  logic                step_en;
  logic                gen_active;

  // The pipeline moves when the result register can take a new value.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance || !s1_valid_r;
  assign step_en  = advance && s1_valid_r;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !advance);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  // Beat generator working on the registered request.
  sdag_beat_gen u_beat_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .result  (step_result),
    .active  (gen_active)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A processed start request leaves a transfer running.
  `SDAG_ASSERT_NEXT(a_start_activates, step_en && (s1_item_r.func == sdag_pkg::FUNC_START), gen_active, "start request did not activate the generator")
  // The final beat of the final row ends the transfer.
  `SDAG_ASSERT_NEXT(a_last_ends, step_en && step_result.last_beat, !gen_active, "generator still active after the last beat")
  // A held request is never dropped while the result side stalls.
  `SDAG_ASSERT_NEXT(a_hold_request, s1_valid_r && !advance, s1_valid_r && $stable(s1_item_r), "pending request lost during an output stall")
  // A beat is only produced while a transfer is running.
  `SDAG_ASSERT_NOW(a_beat_needs_active, step_en && step_result.beat_valid, gen_active, "beat produced with no active transfer")

endmodule
